/* rtl/tcv_pkg.sv */
// ----------------------------------------------------------------------------
// tcv_pkg - shared types and constants for the toroidal convolution block
// Item codes, result status codes, register indexes, the queue entry layout
// and the effective image width helper.
// ----------------------------------------------------------------------------
package tcv_pkg;

	// Default sizes
	localparam int unsigned MAX_WIDTH_DEF   = 64;
	localparam int unsigned MAX_RADIUS_DEF  = 2;
	localparam int unsigned SAMPLE_BITS_DEF = 16;
	localparam int unsigned QUEUE_DEPTH     = 2;

	// Input function codes
	typedef logic [1:0] func_t;
	localparam func_t FUNC_TAP    = 2'd0;
	localparam func_t FUNC_SAMPLE = 2'd1;
	localparam func_t FUNC_CONV   = 2'd2;

	// Result status codes
	typedef logic [1:0] status_t;
	localparam status_t STAT_OK     = 2'd0;
	localparam status_t STAT_POS    = 2'd1;
	localparam status_t STAT_RADIUS = 2'd2;

	// Work kinds handed from the front end to the back end
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_TAP    = 2'd0;
	localparam kind_t KIND_SAMPLE = 2'd1;
	localparam kind_t KIND_CONV   = 2'd2;
	localparam kind_t KIND_ERR    = 2'd3;

	// Configuration register indexes
	typedef logic [0:0] reg_idx_t;
	localparam reg_idx_t REG_IMAGE_WIDTH   = 1'd0;
	localparam reg_idx_t REG_KERNEL_RADIUS = 1'd1;

	// Configuration as seen by the datapath (width already limited)
	typedef struct packed {
		logic [6:0] width;
		logic [1:0] radius;
	} cfg_t;

	// Queue entry: for writes y/x are the target position, for a
	// convolution they are the wrapped top-left corner of the window.
	typedef struct packed {
		kind_t       kind;
		status_t     status;
		logic [6:0]  y;
		logic [6:0]  x;
		logic [15:0] value;
	} entry_t;

	// Limit the programmed width to the image store side
	function automatic logic [6:0] eff_width(logic [6:0] iw, int unsigned max_w);
		return ({2'b00, iw} > 9'(max_w)) ? 7'(max_w) : iw;
	endfunction

endpackage

/* rtl/tcv_front.sv */
// ----------------------------------------------------------------------------
// tcv_front - input stage
// Takes input items, drops the ones with no effect, checks position and
// radius for convolutions and registers one classified entry for the queue.
// ----------------------------------------------------------------------------
module tcv_front #(
	parameter int unsigned MAX_RADIUS = tcv_pkg::MAX_RADIUS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tcv_pkg::cfg_t    cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       func,
	input  logic [5:0]       row,
	input  logic [5:0]       col,
	input  logic [15:0]      value,
	output logic             push_valid,
	input  logic             push_ready,
	output tcv_pkg::entry_t  push_entry
);

	localparam int unsigned KSIDE = 2 * MAX_RADIUS + 1;

	tcv_pkg::entry_t ent;
	logic            keep;
	logic            row_in;
	logic            col_in;
	logic            tap_ok;
	logic            rad_bad;
	logic signed [7:0] y_diff;
	logic signed [7:0] x_diff;
	logic [6:0]      y0;
	logic [6:0]      x0;
	logic            valid_q;
	tcv_pkg::entry_t ent_q;

	// Range checks against the current configuration
	assign row_in  = {1'b0, row} < cfg.width;
	assign col_in  = {1'b0, col} < cfg.width;
	assign tap_ok  = ({1'b0, row} < 7'(KSIDE)) && ({1'b0, col} < 7'(KSIDE));
	assign rad_bad = ({2'b00, cfg.radius} > 4'(MAX_RADIUS)) ||
		({5'b00000, cfg.radius} > cfg.width);

	// Wrapped top-left corner of the window
	assign y_diff = $signed({2'b00, row}) - $signed({6'b000000, cfg.radius});
	assign x_diff = $signed({2'b00, col}) - $signed({6'b000000, cfg.radius});
	assign y0 = y_diff[7] ? 7'(y_diff + $signed({1'b0, cfg.width})) : y_diff[6:0];
	assign x0 = x_diff[7] ? 7'(x_diff + $signed({1'b0, cfg.width})) : x_diff[6:0];

	// Classify the incoming item
	always_comb begin
		ent        = '0;
		ent.y      = {1'b0, row};
		ent.x      = {1'b0, col};
		ent.value  = value;
		ent.status = tcv_pkg::STAT_OK;
		keep       = 1'b0;
		unique case (func)
			tcv_pkg::FUNC_TAP: begin
				ent.kind = tcv_pkg::KIND_TAP;
				keep     = tap_ok;
			end
			tcv_pkg::FUNC_SAMPLE: begin
				ent.kind = tcv_pkg::KIND_SAMPLE;
				keep     = row_in && col_in;
			end
			tcv_pkg::FUNC_CONV: begin
				keep = 1'b1;
				if (!(row_in && col_in)) begin
					ent.kind   = tcv_pkg::KIND_ERR;
					ent.status = tcv_pkg::STAT_POS;
				end else if (rad_bad) begin
					ent.kind   = tcv_pkg::KIND_ERR;
					ent.status = tcv_pkg::STAT_RADIUS;
				end else begin
					ent.kind = tcv_pkg::KIND_CONV;
					ent.y    = y0;
					ent.x    = x0;
				end
			end
			default: begin
				ent.kind = tcv_pkg::KIND_ERR;
				keep     = 1'b0;
			end
		endcase
	end

	// Hold one classified entry until the queue takes it
	assign in_ready   = !valid_q || push_ready;
	assign push_valid = valid_q;
	assign push_entry = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_q <= keep;
		end else if (push_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ent_q <= ent;
		end
	end

endmodule

/* rtl/tcv_fifo.sv */
// ----------------------------------------------------------------------------
// tcv_fifo - work queue
// Short first-in first-out queue of classified entries between the input
// stage and the convolution engine.
// ----------------------------------------------------------------------------
module tcv_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  tcv_pkg::entry_t  push_entry,
	output logic             pop_valid,
	input  logic             pop_ready,
	output tcv_pkg::entry_t  pop_entry
);

	localparam int unsigned DEPTH = tcv_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	tcv_pkg::entry_t slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_entry  = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the new entry
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue occupancy above depth");

endmodule

/* rtl/tcv_back.sv */
// ----------------------------------------------------------------------------
// tcv_back - convolution engine
// Owns the sample and tap memories, performs writes in queue order and runs
// one multiply-accumulate per tap for each convolution, then rounds,
// saturates and registers the result.
// ----------------------------------------------------------------------------
module tcv_back #(
	parameter int unsigned MAX_WIDTH   = tcv_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_RADIUS  = tcv_pkg::MAX_RADIUS_DEF,
	parameter int unsigned SAMPLE_BITS = tcv_pkg::SAMPLE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tcv_pkg::cfg_t    cfg,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  tcv_pkg::entry_t  pop_entry,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [15:0]      filtered_value,
	output logic             saturated,
	output logic [1:0]       status
);

	localparam int unsigned KSIDE     = 2 * MAX_RADIUS + 1;
	localparam int unsigned KTAPS     = KSIDE * KSIDE;
	localparam int unsigned KA_W      = (KTAPS > 1) ? $clog2(KTAPS) : 1;
	localparam int unsigned KC_W      = (KSIDE > 1) ? $clog2(KSIDE) : 1;
	localparam int unsigned IMG_DEPTH = MAX_WIDTH * MAX_WIDTH;
	localparam int unsigned IA_W      = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
	localparam int unsigned SW        = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
	localparam int unsigned PROD_W    = SW + 16;
	localparam int unsigned ACC_W     = PROD_W + $clog2(KTAPS) + 1;

	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2048);
	localparam logic signed [ACC_W-1:0] SAT_HI   =
		ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] SAT_LO   = ~SAT_HI;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [SW-1:0] img_mem [IMG_DEPTH];
	logic [15:0]   ker_mem [KTAPS];

	logic [1:0]        state_q;
	logic [6:0]        y_q;
	logic [6:0]        x_q;
	logic [6:0]        x0_q;
	logic [KC_W-1:0]   ky_q;
	logic [KC_W-1:0]   kx_q;
	logic [KC_W-1:0]   kend;
	logic [7:0]        y_inc;
	logic [7:0]        x_inc;
	logic [6:0]        y_nx;
	logic [6:0]        x_nx;
	logic              out_free;
	logic              out_load;
	logic              start_conv;
	logic              img_we;
	logic              ker_we;
	logic [IA_W+7:0]   ia_wr_full;
	logic [IA_W+7:0]   ia_rd_full;
	logic [KA_W+7:0]   ka_wr_full;
	logic [KA_W+7:0]   ka_rd_full;
	logic [SW-1:0]     img_s1;
	logic [15:0]       ker_s1;
	logic              vld_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic              vld_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  rnd;
	logic signed [ACC_W-1:0]  q_full;
	logic signed [ACC_W-1:0]  q_sat;
	logic              sat_flag;
	logic              out_valid_q;
	logic [15:0]       out_value_q;
	logic              out_sat_q;
	logic [1:0]        out_status_q;

	// Window walk: next row and column with wraparound
	assign kend  = KC_W'({cfg.radius, 1'b0});
	assign y_inc = {1'b0, y_q} + 8'd1;
	assign x_inc = {1'b0, x_q} + 8'd1;
	assign y_nx  = (y_inc == {1'b0, cfg.width}) ? '0 : y_inc[6:0];
	assign x_nx  = (x_inc == {1'b0, cfg.width}) ? '0 : x_inc[6:0];

	// Queue head handling
	assign out_free   = !out_valid_q || out_ready;
	assign pop_ready  = (state_q == ST_IDLE) &&
		((pop_entry.kind != tcv_pkg::KIND_ERR) || out_free);
	assign start_conv = pop_valid && pop_ready && (pop_entry.kind == tcv_pkg::KIND_CONV);
	assign img_we     = pop_valid && pop_ready && (pop_entry.kind == tcv_pkg::KIND_SAMPLE);
	assign ker_we     = pop_valid && pop_ready && (pop_entry.kind == tcv_pkg::KIND_TAP);
	assign out_load   = ((state_q == ST_FIN) && out_free) ||
		(pop_valid && pop_ready && (pop_entry.kind == tcv_pkg::KIND_ERR));

	// Memory addresses
	assign ia_wr_full = (IA_W + 8)'(pop_entry.y) * (IA_W + 8)'(MAX_WIDTH) +
		(IA_W + 8)'(pop_entry.x);
	assign ia_rd_full = (IA_W + 8)'(y_q) * (IA_W + 8)'(MAX_WIDTH) + (IA_W + 8)'(x_q);
	assign ka_wr_full = (KA_W + 8)'(pop_entry.y) * (KA_W + 8)'(KSIDE) +
		(KA_W + 8)'(pop_entry.x);
	assign ka_rd_full = (KA_W + 8)'(ky_q) * (KA_W + 8)'(KSIDE) + (KA_W + 8)'(kx_q);

	// Sample and tap memories
	always_ff @(posedge clk) begin
		if (img_we) begin
			img_mem[ia_wr_full[IA_W-1:0]] <= pop_entry.value[SW-1:0];
		end
		img_s1 <= img_mem[ia_rd_full[IA_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ker_we) begin
			ker_mem[ka_wr_full[KA_W-1:0]] <= pop_entry.value;
		end
		ker_s1 <= ker_mem[ka_rd_full[KA_W-1:0]];
	end

	// Sequencer: walk the (2R+1)^2 window, then drain and finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
		end else begin
			vld_s1 <= state_q == ST_RUN;
			vld_s2 <= vld_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (start_conv) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (kx_q == kend && ky_q == kend) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!vld_s1 && !vld_s2) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Window counters and coordinates
	always_ff @(posedge clk) begin
		if (start_conv) begin
			y_q  <= pop_entry.y;
			x_q  <= pop_entry.x;
			x0_q <= pop_entry.x;
			ky_q <= '0;
			kx_q <= '0;
		end else if (state_q == ST_RUN) begin
			if (kx_q == kend) begin
				kx_q <= '0;
				x_q  <= x0_q;
				y_q  <= y_nx;
				ky_q <= ky_q + 1'b1;
			end else begin
				kx_q <= kx_q + 1'b1;
				x_q  <= x_nx;
			end
		end
	end

	// Multiply, then accumulate
	always_ff @(posedge clk) begin
		prod_s2 <= $signed(img_s1) * $signed(ker_s1);
		if (start_conv) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Round half up to Q8.8 and clamp
	assign rnd    = acc_q + RND_HALF;
	assign q_full = rnd >>> 12;

	always_comb begin
		q_sat    = q_full;
		sat_flag = 1'b0;
		if (q_full > SAT_HI) begin
			q_sat    = SAT_HI;
			sat_flag = 1'b1;
		end else if (q_full < SAT_LO) begin
			q_sat    = SAT_LO;
			sat_flag = 1'b1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == ST_FIN) begin
				out_value_q  <= q_sat[15:0];
				out_sat_q    <= sat_flag;
				out_status_q <= tcv_pkg::STAT_OK;
			end else begin
				out_value_q  <= '0;
				out_sat_q    <= 1'b0;
				out_status_q <= pop_entry.status;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign filtered_value = out_value_q;
	assign saturated      = out_sat_q;
	assign status         = out_status_q;

	a_fin_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |-> !vld_s1 && !vld_s2)
		else $error("result taken before the accumulator settled");

	a_tap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> kx_q <= kend && ky_q <= kend)
		else $error("tap counter beyond kernel edge");

	a_coord_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> x_q < cfg.width && y_q < cfg.width)
		else $error("window coordinate outside the image");

	a_mac_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> state_q == ST_RUN || state_q == ST_DRAIN)
		else $error("accumulate outside a convolution");

endmodule

/* rtl/toroidal_2d_convolution.sv */
// ----------------------------------------------------------------------------
// toroidal_2d_convolution - 2-D convolution with wraparound edges
//
//   channel  direction  handshake              payload
//   input    in         in_valid / in_ready    func, row, col, value
//   result   out        out_valid / out_ready  filtered_value, saturated, status
//   config   in         cfg_we                 cfg_index, cfg_data
//
// A sample or tap write is done as it leaves the queue; an error result is
// registered once the result register is free. A convolution runs as one
// multiply-accumulate per tap through the single read port of the sample
// memory, plus read, multiply, drain and round. The input stage takes one
// item per cycle while the queue has room, and a waiting result does not
// stop it. Reset clears control only; sample and tap memories hold nothing
// defined until written.
// ----------------------------------------------------------------------------
module toroidal_2d_convolution #(
	parameter int unsigned MAX_WIDTH   = tcv_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_RADIUS  = tcv_pkg::MAX_RADIUS_DEF,
	parameter int unsigned SAMPLE_BITS = tcv_pkg::SAMPLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [5:0]  row,
	input  logic [5:0]  col,
	input  logic [15:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] filtered_value,
	output logic        saturated,
	output logic [1:0]  status,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [6:0]  cfg_data
);

	logic [6:0]      image_width_q;
	logic [1:0]      kernel_radius_q;
	tcv_pkg::cfg_t   cfg;
	logic            push_valid;
	logic            push_ready;
	tcv_pkg::entry_t push_entry;
	logic            pop_valid;
	logic            pop_ready;
	tcv_pkg::entry_t pop_entry;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= 7'd64;
			kernel_radius_q <= 2'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tcv_pkg::REG_IMAGE_WIDTH:   image_width_q   <= cfg_data;
				tcv_pkg::REG_KERNEL_RADIUS: kernel_radius_q <= cfg_data[1:0];
				default: begin
					image_width_q <= image_width_q;
				end
			endcase
		end
	end

	assign cfg.width  = tcv_pkg::eff_width(image_width_q, MAX_WIDTH);
	assign cfg.radius = kernel_radius_q;

	tcv_front #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.row        (row),
		.col        (col),
		.value      (value),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	tcv_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	tcv_back #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_RADIUS  (MAX_RADIUS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.pop_valid      (pop_valid),
		.pop_ready      (pop_ready),
		.pop_entry      (pop_entry),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.filtered_value (filtered_value),
		.saturated      (saturated),
		.status         (status)
	);

endmodule
